### src/mcc2d_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel 2D convolution package
// Shared sizes, register indexes, opcodes, beat types and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package mcc2d_pkg;
  localparam int MaxWidth    = 256;
  localparam int MaxChannels = 8;
  localparam int MaxKernel   = 5;
  localparam int MaxFilters  = 16;
  localparam int MaxRows     = 4096;
  localparam int WDepth = MaxFilters * MaxKernel * MaxKernel * MaxChannels;
  localparam int RDepth = MaxKernel * MaxWidth * MaxChannels;
  localparam int WAW = $clog2(WDepth);
  localparam int RAW = $clog2(RDepth);

  localparam logic [2:0] REG_ROWS     = 3'd0;
  localparam logic [2:0] REG_COLS     = 3'd1;
  localparam logic [2:0] REG_CHANNELS = 3'd2;
  localparam logic [2:0] REG_KERNEL   = 3'd3;
  localparam logic [2:0] REG_FILTERS  = 3'd4;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic        opcode;
    logic [11:0] weight_index;
    logic signed [15:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [7:0]  out_col;
    logic [3:0]  filter_index;
    logic signed [47:0] result;
    logic        last;
  } out_beat_t;
endpackage
`default_nettype wire

### src/mcc2d_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for input and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface mcc2d_in_if import mcc2d_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcc2d_out_if import mcc2d_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/mcc2d_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module mcc2d_ram #(
  parameter int Depth = 16,
  parameter int Width = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/multichannel_conv2d_valid_top.sv
// A weight beat or a non-completing sample is taken whenever the block is idle.
// A sample that completes a window holds the input until the last filter's result is emitted.
// The single multiply-accumulate unit takes one tap per cycle from the weight
// and row memories, then drains its pipeline and emits each filter's result.
// Throughput: one beat per cycle outside windows.
// Reset (rst_n low, synchronous) clears registers to defaults and counters.
// ----------------------------------------------------------------------------
// Multichannel 2D convolution, valid mode, stride 1
// Weight store and rolling row store in RAM, one shared MAC unit.
// ----------------------------------------------------------------------------
`default_nettype none
module multichannel_conv2d_valid_top import mcc2d_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata,
  mcc2d_in_if.sink         in_ch,
  mcc2d_out_if.source      out_ch
);
  // Configuration registers.
  logic [12:0] rows_r;
  logic [8:0]  cols_r;
  logic [3:0]  nch_r;
  logic [2:0]  k_r;
  logic [4:0]  nf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 13'd1; cols_r <= 9'd1; nch_r <= 4'd1; k_r <= 3'd3; nf_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:     rows_r <= cfg_wdata;
        REG_COLS:     cols_r <= cfg_wdata[8:0];
        REG_CHANNELS: nch_r  <= cfg_wdata[3:0];
        REG_KERNEL:   k_r    <= cfg_wdata[2:0];
        REG_FILTERS:  nf_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry.
  logic [12:0] rows;
  logic [8:0]  cols;
  logic [3:0]  nch;
  logic [2:0]  k;
  logic [4:0]  nf;
  always_comb begin
    rows = (rows_r == '0) ? 13'd1 : (rows_r > 13'(MaxRows)) ? 13'(MaxRows) : rows_r;
    cols = (cols_r == '0) ? 9'd1 : (cols_r > 9'(MaxWidth)) ? 9'(MaxWidth) : cols_r;
    nch  = (nch_r == '0) ? 4'd1 : (nch_r > 4'(MaxChannels)) ? 4'(MaxChannels) : nch_r;
    k    = (k_r == '0) ? 3'd1 : (k_r > 3'(MaxKernel)) ? 3'(MaxKernel) : k_r;
    nf   = (nf_r == '0) ? 5'd1 : (nf_r > 5'(MaxFilters)) ? 5'(MaxFilters) : nf_r;
  end

  // Position counters, with the row residues mod 3 and mod 5 kept alongside
  // so that the row slot (row mod K) follows any kernel size.
  logic [11:0] row_r;
  logic [7:0]  col_r;
  logic [2:0]  ch_r;
  logic [1:0]  m3_r;
  logic [2:0]  m5_r;
  state_t      state_r, state_nxt;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  logic is_sample;
  assign is_sample = in_ch.data.opcode == OP_SAMPLE;

  // Effective position after a restart for changed geometry.
  logic        restart;
  logic [11:0] prow;
  logic [7:0]  pcol;
  logic [2:0]  pch;
  logic [1:0]  pm3;
  logic [2:0]  pm5;
  logic [2:0]  pslot;
  always_comb begin
    restart = ({1'b0, row_r} >= rows) || ({1'b0, col_r} >= cols) ||
              ({1'b0, ch_r} >= nch);
    prow  = restart ? '0 : row_r;
    pcol  = restart ? '0 : col_r;
    pch   = restart ? '0 : ch_r;
    pm3   = restart ? '0 : m3_r;
    pm5   = restart ? '0 : m5_r;
    unique case (k)
      3'd1:    pslot = 3'd0;
      3'd2:    pslot = {2'd0, prow[0]};
      3'd3:    pslot = {1'b0, pm3};
      3'd4:    pslot = {1'b0, prow[1:0]};
      default: pslot = pm5;
    endcase
  end

  logic completes;
  assign completes = ({1'b0, pch} == nch - 4'd1) &&
                     (prow >= 12'(k - 3'd1)) && ({4'd0, pcol} >= 12'(k - 3'd1));

  // Window scan registers.
  logic [11:0] r0_r;
  logic [7:0]  c0_r;
  logic [2:0]  base_slot_r;  // slot of row r0
  logic [3:0]  f_r;
  logic [2:0]  kr_r, kc_r, ch_s_r;
  logic [2:0]  sl_r;         // slot of row r0+kr
  logic [WAW-1:0] wa_r;       // running weight address
  logic        tap_v_r, tap_v2_r;
  logic        tap_last_r, tap_last2_r;
  logic signed [31:0] prod_r;
  logic signed [47:0] acc_r;
  out_beat_t   ob_r;
  logic        ov_r;

  // Memories.
  logic [RAW-1:0] rs_waddr, rs_raddr;
  logic [15:0]    rs_rdata, ws_rdata;
  logic           ws_we;
  logic [WAW-1:0] ws_raddr;

  assign ws_we = accept && !is_sample && (in_ch.data.weight_index < 12'(WDepth));
  assign rs_waddr = RAW'(({2'd0, pslot} * 11'(MaxWidth) + {3'd0, pcol}) *
                         14'(MaxChannels) + {11'd0, pch});
  logic [7:0] ccol;
  assign ccol = c0_r + {5'd0, kc_r};
  assign rs_raddr = RAW'(({2'd0, sl_r} * 11'(MaxWidth) + {3'd0, ccol}) *
                         14'(MaxChannels) + {11'd0, ch_s_r});
  assign ws_raddr = wa_r;

  mcc2d_ram #(.Depth(WDepth), .Width(16)) u_wstore (
    .clk, .we(ws_we), .waddr(in_ch.data.weight_index[WAW-1:0]),
    .wdata(in_ch.data.value), .raddr(ws_raddr), .rdata(ws_rdata));
  mcc2d_ram #(.Depth(RDepth), .Width(16)) u_rstore (
    .clk, .we(accept && is_sample), .waddr(rs_waddr),
    .wdata(in_ch.data.value), .raddr(rs_raddr), .rdata(rs_rdata));

  // Handshake outputs; the output register lets input flow while a beat waits.
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = ob_r;

  logic emit_go;
  assign emit_go = (state_r == ST_EMIT) && (!ov_r || out_ch.ready);

  logic tap_end;
  assign tap_end = ({1'b0, ch_s_r} == nch - 4'd1) && (kc_r == k - 3'd1) &&
                   (kr_r == k - 3'd1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && is_sample && completes) state_nxt = ST_MAC;
      ST_MAC:   if (tap_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (tap_last2_r) state_nxt = ST_EMIT;
      ST_EMIT:  if (!ov_r || out_ch.ready) begin
        state_nxt = ({1'b0, f_r} == nf - 5'd1) ? ST_IDLE : ST_MAC;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r <= '0; col_r <= '0; ch_r <= '0; m3_r <= '0; m5_r <= '0;
      ov_r <= 1'b0; tap_v_r <= 1'b0; tap_v2_r <= 1'b0;
      tap_last_r <= 1'b0; tap_last2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      // Tap pipeline: address -> memory read -> product -> accumulate.
      tap_v_r    <= (state_r == ST_MAC);
      tap_last_r <= (state_r == ST_MAC) && tap_end;
      tap_v2_r   <= tap_v_r;
      tap_last2_r <= tap_last_r;
      prod_r <= $signed(ws_rdata) * $signed(rs_rdata);
      if (tap_v2_r) acc_r <= acc_r + 48'(prod_r);

      unique case (state_r)
        ST_IDLE: if (accept && is_sample) begin
          // Advance the raster position.
          if ({1'b0, pch} + 4'd1 >= nch) begin
            ch_r <= '0;
            if ({1'b0, pcol} + 9'd1 >= cols) begin
              col_r <= '0;
              if ({1'b0, prow} + 13'd1 >= rows) begin
                row_r <= '0; m3_r <= '0; m5_r <= '0;
              end else begin
                row_r <= prow + 12'd1;
                m3_r <= (pm3 == 2'd2) ? 2'd0 : pm3 + 2'd1;
                m5_r <= (pm5 == 3'd4) ? 3'd0 : pm5 + 3'd1;
              end
            end else begin
              col_r <= pcol + 8'd1; row_r <= prow; m3_r <= pm3; m5_r <= pm5;
            end
          end else begin
            ch_r <= pch + 3'd1; col_r <= pcol; row_r <= prow; m3_r <= pm3; m5_r <= pm5;
          end
          if (completes) begin
            r0_r <= prow - 12'(k - 3'd1);
            c0_r <= pcol - 8'(k - 3'd1);
            // Row r0 sits one slot after the current row, modulo K.
            base_slot_r <= (pslot + 3'd1 >= k) ? 3'd0 : pslot + 3'd1;
            sl_r <= (pslot + 3'd1 >= k) ? 3'd0 : pslot + 3'd1;
            f_r <= '0; kr_r <= '0; kc_r <= '0; ch_s_r <= '0;
            wa_r <= '0; acc_r <= '0;
          end
        end
        ST_MAC: begin
          wa_r <= wa_r + WAW'(1);
          if ({1'b0, ch_s_r} == nch - 4'd1) begin
            ch_s_r <= '0;
            if (kc_r == k - 3'd1) begin
              kc_r <= '0;
              kr_r <= kr_r + 3'd1;
              sl_r <= (sl_r + 3'd1 >= k) ? 3'd0 : sl_r + 3'd1;
            end else begin
              kc_r <= kc_r + 3'd1;
            end
          end else begin
            ch_s_r <= ch_s_r + 3'd1;
          end
        end
        ST_DRAIN: ;
        ST_EMIT: if (!ov_r || out_ch.ready) begin
          ob_r.out_row <= r0_r;
          ob_r.out_col <= c0_r;
          ob_r.filter_index <= f_r;
          ob_r.result <= acc_r;
          ob_r.last <= ({1'b0, f_r} == nf - 5'd1);
          f_r <= f_r + 4'd1;
          kr_r <= '0; kc_r <= '0; ch_s_r <= '0;
          sl_r <= base_slot_r;
          acc_r <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/mcc2d_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Assertions on the top level's ports, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none
module mcc2d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_filter,
  input wire logic        out_last
);
  // A waiting result beat stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  // A waiting result beat keeps its contents.
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_filter) && $stable(out_last))
    else $error("result beat changed while waiting");

  // While a non-last beat is pending, more filters remain and input waits.
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("filter sequence cut short");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind multichannel_conv2d_valid_top mcc2d_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_filter(out_ch.data.filter_index), .out_last(out_ch.data.last));
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the multichannel 2D convolution block
// Loads filter weights, streams images through several geometries, and
// compares every result beat with an in-bench convolution model or a directed
// table entry under sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import mcc2d_pkg::*;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t typed_exp;
  } stim_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [12:0] cdata;
    logic        op;
    logic [11:0] widx;
    logic signed [15:0] val;
    bit          typed;
    logic [7:0]  col;
    logic signed [47:0] res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_ROWS;
  logic [12:0] cfg_wdata = '0;

  mcc2d_in_if  in_ch ();
  mcc2d_out_if out_ch ();

  multichannel_conv2d_valid_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copies of the registers, as written.
  logic [12:0] rows_reg = 13'd1;
  logic [8:0]  cols_reg = 9'd1;
  logic [3:0]  chan_reg = 4'd1;
  logic [2:0]  kern_reg = 3'd3;
  logic [4:0]  filt_reg = 5'd1;

  // Convolution state kept by the bench.
  logic signed [15:0] weight_mem [WDepth];
  logic signed [15:0] line_mem [RDepth];
  int pos_row = 0, pos_col = 0, pos_ch = 0;

  stim_t     beat_q[$];
  stim_t     cur_stim;
  out_beat_t want_results[$];
  dir_row_t  dir_tab[$];

  int idle_pct = 0, stall_pct = 0;
  logic hold_on = 1'b0;
  event hold_trig;
  int errors = 0, beats_in = 0, results_seen = 0, phases = 0;

  function automatic int clamp_reg(int v, int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int eff_rows();  return clamp_reg(rows_reg, MaxRows);     endfunction
  function automatic int eff_cols();  return clamp_reg(cols_reg, MaxWidth);    endfunction
  function automatic int eff_chan();  return clamp_reg(chan_reg, MaxChannels); endfunction
  function automatic int eff_kern();  return clamp_reg(kern_reg, MaxKernel);   endfunction
  function automatic int eff_filt();  return clamp_reg(filt_reg, MaxFilters);  endfunction

  // Take one accepted beat and queue the results it must produce.
  task automatic conv_step(stim_t s);
    int rows, cols, nch, k, nf, r0, c0, slot;
    longint acc;
    out_beat_t e;
    rows = eff_rows(); cols = eff_cols(); nch = eff_chan(); k = eff_kern(); nf = eff_filt();
    if (s.beat.opcode == OP_WEIGHT) begin
      if (s.beat.weight_index < WDepth) weight_mem[s.beat.weight_index] = s.beat.value;
      return;
    end
    // A counter past its (new) limit restarts the image.
    if (pos_row >= rows || pos_col >= cols || pos_ch >= nch) begin
      pos_row = 0; pos_col = 0; pos_ch = 0;
    end
    line_mem[((pos_row % k) * MaxWidth + pos_col) * MaxChannels + pos_ch] = s.beat.value;
    if (pos_ch == nch - 1 && pos_row >= k - 1 && pos_col >= k - 1) begin
      r0 = pos_row - (k - 1);
      c0 = pos_col - (k - 1);
      for (int f = 0; f < nf; f++) begin
        acc = 0;
        for (int kr = 0; kr < k; kr++) begin
          slot = (r0 + kr) % k;
          for (int kc = 0; kc < k; kc++)
            for (int ch = 0; ch < nch; ch++)
              acc += longint'(weight_mem[((f * k + kr) * k + kc) * nch + ch]) *
                     longint'(line_mem[(slot * MaxWidth + c0 + kc) * MaxChannels + ch]);
        end
        e.out_row      = r0[11:0];
        e.out_col      = c0[7:0];
        e.filter_index = f[3:0];
        e.result       = acc[47:0];
        e.last         = (f == nf - 1);
        want_results.push_back(s.typed ? s.typed_exp : e);
      end
    end
    pos_ch++;
    if (pos_ch >= nch) begin
      pos_ch = 0;
      pos_col++;
      if (pos_col >= cols) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= rows) pos_row = 0;
      end
    end
  endtask

  // Input side: record the accepted beat, then offer the next one.
  always @(posedge clk) begin : in_driver
    stim_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        conv_step(cur_stim);
        beats_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = beat_q.pop_front();
          cur_stim    <= nxt;
          in_ch.data  <= nxt.beat;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls, plus the long hold-off when asked.
  always @(posedge clk) begin
    out_ch.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  always begin
    @(hold_trig);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_beat_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      results_seen++;
      if (want_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d col %0d filter %0d value %0d", $time,
                 a.out_row, a.out_col, a.filter_index, a.result);
      end else begin
        e = want_results.pop_front();
        if (a.out_row !== e.out_row || a.out_col !== e.out_col ||
            a.filter_index !== e.filter_index || a.result !== e.result ||
            a.last !== e.last) begin
          errors++;
          $display("%0t: mismatch expected row %0d col %0d filter %0d value %0d last %0b",
                   $time, e.out_row, e.out_col, e.filter_index, e.result, e.last);
          $display("%0t:          actual   row %0d col %0d filter %0d value %0d last %0b",
                   $time, a.out_row, a.out_col, a.filter_index, a.result, a.last);
        end
      end
    end
  end

  task automatic push_beat(logic op, logic [11:0] widx, logic signed [15:0] val,
                           bit typed = 0, out_beat_t exp_beat = '0);
    stim_t s;
    s.beat.opcode = op;
    s.beat.weight_index = widx;
    s.beat.value = val;
    s.typed = typed;
    s.typed_exp = exp_beat;
    beat_q.push_back(s);
  endtask

  function automatic logic signed [15:0] rand_val();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return $urandom();
    endcase
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [12:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_ROWS:     rows_reg = v[12:0];
      REG_COLS:     cols_reg = v[8:0];
      REG_CHANNELS: chan_reg = v[3:0];
      REG_KERNEL:   kern_reg = v[2:0];
      REG_FILTERS:  filt_reg = v[4:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block is idle once everything queued has gone in and every result came out.
  task automatic wait_idle();
    do @(negedge clk); while (beat_q.size() > 0 || in_ch.valid || want_results.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_geom(int r, int c, int ch, int k, int f);
    wait_idle();
    cfg_write(REG_ROWS, r);
    cfg_write(REG_COLS, c);
    cfg_write(REG_CHANNELS, ch);
    cfg_write(REG_KERNEL, k);
    cfg_write(REG_FILTERS, f);
    cfg_done();
    phases++;
  endtask

  task automatic set_mode(int m);
    case (m % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 85; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 85; end
      default: begin idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  // Write every weight that the current geometry reads.
  task automatic load_weights();
    int n;
    n = eff_filt() * eff_kern() * eff_kern() * eff_chan();
    for (int i = 0; i < n; i++) push_beat(OP_WEIGHT, i[11:0], rand_val());
  endtask

  task automatic push_samples(int n);
    for (int i = 0; i < n; i++) push_beat(OP_SAMPLE, $urandom(), rand_val());
  endtask

  function automatic int img_size();
    return eff_rows() * eff_cols() * eff_chan();
  endfunction

  task automatic add_cfg(logic [2:0] idx, logic [12:0] v);
    dir_row_t d;
    d = '{default: '0};
    d.is_cfg = 1; d.idx = idx; d.cdata = v;
    dir_tab.push_back(d);
  endtask

  task automatic add_beat(logic op, logic [11:0] widx, logic signed [15:0] val,
                          bit typed = 0, logic [7:0] col = 0, logic signed [47:0] res = 0);
    dir_row_t d;
    d = '{default: '0};
    d.op = op; d.widx = widx; d.val = val; d.typed = typed; d.col = col; d.res = res;
    dir_tab.push_back(d);
  endtask

  initial begin
    out_beat_t tx;
    int k, nw;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: one-pixel kernel first, so results read off directly.
    add_cfg(REG_ROWS, 1); add_cfg(REG_COLS, 2); add_cfg(REG_CHANNELS, 1);
    add_cfg(REG_KERNEL, 1); add_cfg(REG_FILTERS, 1);
    add_beat(OP_WEIGHT, 0, -16'sd32768);
    add_beat(OP_SAMPLE, 0, -16'sd32768, 1, 0, 48'sd1073741824);
    add_beat(OP_SAMPLE, 0, 16'sd32767, 1, 1, -48'sd1073709056);
    // Writes beyond the weight store are dropped.
    add_beat(OP_WEIGHT, 12'd4095, 16'sh5a5a);
    add_beat(OP_WEIGHT, 12'd3200, -16'sd1);
    add_beat(OP_WEIGHT, 0, 16'sd32767);
    add_beat(OP_SAMPLE, 0, 16'sd32767, 1, 0, 48'sd1073676289);
    add_beat(OP_SAMPLE, 12'hfff, 16'sd0, 1, 1, 48'sd0);
    // Kernel wider than the image: no window ever completes.
    add_cfg(REG_KERNEL, 3);
    add_beat(OP_SAMPLE, 0, 16'sd1234);
    add_beat(OP_SAMPLE, 0, -16'sd5);
    // Zero in every register acts as one.
    add_cfg(REG_ROWS, 0); add_cfg(REG_COLS, 0); add_cfg(REG_CHANNELS, 0);
    add_cfg(REG_KERNEL, 0); add_cfg(REG_FILTERS, 0);
    add_beat(OP_WEIGHT, 0, -16'sd1);
    add_beat(OP_SAMPLE, 0, 16'sd5, 1, 0, -48'sd5);
    add_beat(OP_SAMPLE, 0, -16'sd32768, 1, 0, 48'sd32768);
    // All-ones in every register clamps to the maximum.
    add_cfg(REG_ROWS, 13'h1fff); add_cfg(REG_COLS, 9'h1ff); add_cfg(REG_CHANNELS, 4'hf);
    add_cfg(REG_KERNEL, 3'h7); add_cfg(REG_FILTERS, 5'h1f);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        cfg_write(dir_tab[i].idx, dir_tab[i].cdata);
        cfg_done();
      end else begin
        tx = '0;
        tx.out_col = dir_tab[i].col;
        tx.result = dir_tab[i].res;
        tx.last = 1'b1;
        push_beat(dir_tab[i].op, dir_tab[i].widx, dir_tab[i].val, dir_tab[i].typed, tx);
      end
    end

    // Widest image line.
    set_geom(1, 256, 1, 1, 1);
    load_weights(); push_samples(img_size());

    // Sixteen filters; the receiver holds off so the block backs up.
    set_geom(2, 8, 1, 1, 16);
    load_weights(); push_samples(img_size());
    -> hold_trig;

    // Largest kernel and most channels.
    set_mode(3);
    set_geom(5, 6, 1, 5, 1);
    load_weights(); push_samples(img_size());
    set_geom(2, 2, 8, 1, 2);
    load_weights(); push_samples(img_size());

    // Tallest image, left partly sent; the next geometry restarts it.
    set_mode(1);
    set_geom(4096, 1, 1, 1, 1);
    load_weights(); push_samples(12);

    // Geometry changed mid-image: rows shrink below the current row.
    set_mode(2);
    set_geom(3, 4, 2, 2, 2);
    load_weights(); push_samples(19);
    wait_idle();
    cfg_write(REG_ROWS, 2);
    cfg_done();
    push_samples(img_size());

    // Random geometries with whole images and stray weight writes.
    for (int p = 0; beats_in + beat_q.size() < 470; p++) begin
      set_mode(p);
      k = ($urandom_range(7) == 0) ? 4 : $urandom_range(1, 3);
      set_geom(($urandom_range(7) == 0) ? $urandom_range(1, k) : k - 1 + $urandom_range(1, 3),
               k - 1 + $urandom_range(1, 4), $urandom_range(1, 2), k,
               $urandom_range(1, 3));
      load_weights();
      nw = eff_filt() * k * k * eff_chan();
      for (int i = 0; i < img_size(); i++) begin
        case ($urandom_range(11))
          0: push_beat(OP_WEIGHT, $urandom_range(WDepth, 4095), rand_val());
          1: push_beat(OP_WEIGHT, $urandom_range(0, nw - 1), rand_val());
          default: ;
        endcase
        push_samples(1);
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Ran %0d geometries, %0d input beats, %0d result beats checked.",
             phases, beats_in, results_seen);
    $display("Covered register clamping, dropped weight writes, image restarts and stalls.");
    if (errors == 0 && want_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule
